### design/cop_pkg.sv
// ----------------------------------------------------------------------------
// cop_pkg: shared types and constants of the CoAP option parser
// Kind and error codes, option header constants, and the record bundle
// that the parser hands to the output side.
// ----------------------------------------------------------------------------
package cop_pkg;

   // byte counter width, wraps
   localparam int unsigned INDEX_BITS = 16;

   // result kinds
   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_BAD_NIBBLE   = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED    = 2'd2;
   localparam logic [1:0] ERR_INT_TOO_LONG = 2'd3;

   // option header nibbles and extension bases
   localparam logic [3:0]  NIB_FORBIDDEN = 4'd15;
   localparam logic [3:0]  NIB_EXT1      = 4'd13;
   localparam logic [3:0]  NIB_EXT2      = 4'd14;
   localparam logic [15:0] EXT1_BASE     = 16'd13;
   localparam logic [15:0] EXT2_BASE     = 16'd269;
   localparam logic [7:0]  MARKER        = 8'hFF;
   localparam logic [15:0] INT_MAX_BYTES = 16'd4;

   // bundle queue between parser and output stage
   localparam int unsigned QUEUE_DEPTH      = 4;
   localparam int unsigned QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // what one input byte causes: an optional record or value byte,
   // then an optional end or error
   typedef struct packed {
      logic        has_rec;
      logic [1:0]  rec_kind;
      logic [15:0] rec_number;
      logic [15:0] rec_length;
      logic        rec_is_integer;
      logic [31:0] rec_integer;
      logic [7:0]  rec_byte;
      logic        has_end;
      logic [1:0]  end_kind;
      logic [1:0]  end_error;
      logic [15:0] end_consumed;
   } bundle_type;

   function automatic logic is_integer_option(input logic [15:0] number);
      return number inside {16'd6, 16'd7, 16'd12, 16'd14, 16'd17,
                            16'd23, 16'd27, 16'd28, 16'd60, 16'd258};
   endfunction

endpackage

### design/coap_option_parser.sv
// ----------------------------------------------------------------------------
// coap_option_parser: streaming CoAP option area decoder
// Parses option headers, extensions and values one byte at a time and
// emits option records, value bytes, and end or error results.
// ----------------------------------------------------------------------------
// One option-area byte is taken every cycle while full is low. The parser
// handles each byte in the cycle it is transferred and writes what it causes
// into a four-entry bundle queue; a result passes through the queue and the
// output register before it shows on the rsp_ ports. The output register
// gives one result per cycle while results are taken, so a byte that causes
// two results (a record or value byte followed by an end or an error) holds
// the result side for both in turn, and a long run of such bytes fills the
// queue and then holds input back through full. No clearing pass after reset.

module coap_option_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_option_number,
   output logic [15:0] rsp_value_length,
   output logic        rsp_is_integer,
   output logic [31:0] rsp_integer_value,
   output logic [7:0]  rsp_value_byte,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_consumed_length,
   output logic        rsp_end_of_run,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic                int_rule_en_ff, int_rule_en_in;
   logic                accept;
   logic                q_push, q_pop, q_full, q_empty;
   cop_pkg::bundle_type q_wr_data, q_head;

   assign int_rule_en_in = csr_write_enable ? csr_write_data : int_rule_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_rule_en_ff <= 1'b1;
      end else begin
         int_rule_en_ff <= int_rule_en_in;
      end
   end

   assign full   = q_full;
   assign accept = push && !q_full;

   cop_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .int_rule_en (int_rule_en_ff),
      .q_push      (q_push),
      .q_data      (q_wr_data)
   );

   cop_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   cop_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (q_head),
      .head_valid          (!q_empty),
      .head_pop            (q_pop),
      .rsp_pop             (pop),
      .rsp_empty           (empty),
      .rsp_kind            (rsp_kind),
      .rsp_option_number   (rsp_option_number),
      .rsp_value_length    (rsp_value_length),
      .rsp_is_integer      (rsp_is_integer),
      .rsp_integer_value   (rsp_integer_value),
      .rsp_value_byte      (rsp_value_byte),
      .rsp_error_code      (rsp_error_code),
      .rsp_consumed_length (rsp_consumed_length),
      .rsp_end_of_run      (rsp_end_of_run)
   );

`ifndef ASSERT_OFF
   // the parser only writes the queue for a transferred byte
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (push && !full))
      else $error("bundle written without an input transfer");

   // the output stage never takes from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("bundle taken from an empty queue");

   // an end or an error is always the last result of its byte
   assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_kind == cop_pkg::KIND_END || rsp_kind == cop_pkg::KIND_ERROR))
      |-> rsp_end_of_run)
      else $error("end or error result not marked end of run");

   // the rest of a byte's results follows straight after a non-final one
   assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_end_of_run) |=> !empty)
      else $error("second result of a byte missing");
`endif

endmodule

### design/cop_front.sv
// ----------------------------------------------------------------------------
// cop_front: option header and value parser
// Takes one option-area byte per cycle while accept is high, tracks the
// parse phase and builds the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module cop_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic                 int_rule_en,
   output logic                 q_push,
   output cop_pkg::bundle_type  q_data
);

   localparam logic [2:0] PH_HEADER    = 3'd0;
   localparam logic [2:0] PH_DELTA_EXT = 3'd1;
   localparam logic [2:0] PH_LEN_EXT   = 3'd2;
   localparam logic [2:0] PH_OPAQUE    = 3'd3;
   localparam logic [2:0] PH_INT       = 3'd4;
   localparam logic [2:0] PH_BAD_INT   = 3'd5;
   localparam logic [2:0] PH_IDLE      = 3'd6;

   logic [2:0]                     phase_ff,  phase_in;
   logic [15:0]                    number_ff, number_in;
   logic [15:0]                    delta_ff,  delta_in;
   logic [15:0]                    length_ff, length_in;
   logic [15:0]                    remain_ff, remain_in;
   logic [31:0]                    acc_ff,    acc_in;
   logic [cop_pkg::INDEX_BITS-1:0] index_ff,  index_in;
   cop_pkg::bundle_type            bun;

   always_comb begin
      logic [3:0] dn;
      logic [3:0] nib;
      logic       do_len_nib;
      logic       do_finish;
      logic       do_done;
      logic       do_clear;
      logic       isint;

      phase_in   = phase_ff;
      number_in  = number_ff;
      delta_in   = delta_ff;
      length_in  = length_ff;
      remain_in  = remain_ff;
      acc_in     = acc_ff;
      index_in   = index_ff;
      bun        = '0;
      bun.rec_kind  = cop_pkg::KIND_RECORD;
      bun.end_kind  = cop_pkg::KIND_END;
      bun.end_error = cop_pkg::ERR_NONE;
      dn         = data_byte[7:4];
      nib        = data_byte[3:0];
      do_len_nib = 1'b0;
      do_finish  = 1'b0;
      do_done    = 1'b0;
      do_clear   = 1'b0;
      isint      = 1'b0;

      if (accept) begin
         if (phase_ff == PH_IDLE) begin
            do_clear = last_byte;
         end else begin
            index_in = index_ff + 1'b1;
            case (phase_ff)
               PH_HEADER: begin
                  if (data_byte == cop_pkg::MARKER) begin
                     bun.has_end      = 1'b1;
                     bun.end_consumed = 16'(index_ff);
                  end else if (dn == cop_pkg::NIB_FORBIDDEN) begin
                     bun.has_end   = 1'b1;
                     bun.end_kind  = cop_pkg::KIND_ERROR;
                     bun.end_error = cop_pkg::ERR_BAD_NIBBLE;
                  end else if (dn == cop_pkg::NIB_EXT1 || dn == cop_pkg::NIB_EXT2) begin
                     delta_in  = (dn == cop_pkg::NIB_EXT1) ? cop_pkg::EXT1_BASE
                                                          : cop_pkg::EXT2_BASE;
                     remain_in = (dn == cop_pkg::NIB_EXT1) ? 16'd1 : 16'd2;
                     length_in = 16'(data_byte[3:0]);
                     phase_in  = PH_DELTA_EXT;
                     if (last_byte) begin
                        bun.has_end   = 1'b1;
                        bun.end_kind  = cop_pkg::KIND_ERROR;
                        bun.end_error = cop_pkg::ERR_TRUNCATED;
                     end
                  end else begin
                     delta_in   = 16'(dn);
                     do_len_nib = 1'b1;
                  end
               end
               PH_DELTA_EXT: begin
                  if (remain_ff >= 16'd2) begin
                     delta_in  = delta_ff + {data_byte, 8'h00};
                     remain_in = 16'd1;
                     if (last_byte) begin
                        bun.has_end   = 1'b1;
                        bun.end_kind  = cop_pkg::KIND_ERROR;
                        bun.end_error = cop_pkg::ERR_TRUNCATED;
                     end
                  end else begin
                     delta_in   = delta_ff + 16'(data_byte);
                     remain_in  = 16'd0;
                     nib        = length_ff[3:0];
                     do_len_nib = 1'b1;
                  end
               end
               PH_LEN_EXT: begin
                  if (remain_ff >= 16'd2) begin
                     length_in = length_ff + {data_byte, 8'h00};
                     remain_in = 16'd1;
                     if (last_byte) begin
                        bun.has_end   = 1'b1;
                        bun.end_kind  = cop_pkg::KIND_ERROR;
                        bun.end_error = cop_pkg::ERR_TRUNCATED;
                     end
                  end else begin
                     length_in = length_ff + 16'(data_byte);
                     remain_in = 16'd0;
                     do_finish = 1'b1;
                  end
               end
               PH_OPAQUE: begin
                  bun.has_rec    = 1'b1;
                  bun.rec_kind   = cop_pkg::KIND_VALUE;
                  bun.rec_number = number_ff;
                  bun.rec_length = length_ff;
                  bun.rec_byte   = data_byte;
                  remain_in      = remain_ff - 16'd1;
                  if (remain_in == 16'd0) begin
                     do_done = 1'b1;
                  end else if (last_byte) begin
                     bun.has_end   = 1'b1;
                     bun.end_kind  = cop_pkg::KIND_ERROR;
                     bun.end_error = cop_pkg::ERR_TRUNCATED;
                  end
               end
               PH_INT: begin
                  acc_in    = {acc_ff[23:0], data_byte};
                  remain_in = remain_ff - 16'd1;
                  if (remain_in == 16'd0) begin
                     bun.has_rec        = 1'b1;
                     bun.rec_number     = number_ff;
                     bun.rec_length     = length_ff;
                     bun.rec_is_integer = 1'b1;
                     bun.rec_integer    = acc_in;
                     do_done            = 1'b1;
                  end else if (last_byte) begin
                     bun.has_end   = 1'b1;
                     bun.end_kind  = cop_pkg::KIND_ERROR;
                     bun.end_error = cop_pkg::ERR_TRUNCATED;
                  end
               end
               PH_BAD_INT: begin
                  remain_in = remain_ff - 16'd1;
                  bun.has_end  = (remain_in == 16'd0) || last_byte;
                  bun.end_kind = cop_pkg::KIND_ERROR;
                  bun.end_error = (remain_in == 16'd0) ? cop_pkg::ERR_INT_TOO_LONG
                                                       : cop_pkg::ERR_TRUNCATED;
               end
               default: begin
                  do_clear = 1'b1;
               end
            endcase

            // length nibble, once the delta is complete
            if (do_len_nib) begin
               if (nib == cop_pkg::NIB_FORBIDDEN) begin
                  bun.has_end   = 1'b1;
                  bun.end_kind  = cop_pkg::KIND_ERROR;
                  bun.end_error = cop_pkg::ERR_BAD_NIBBLE;
               end else if (nib == cop_pkg::NIB_EXT1 || nib == cop_pkg::NIB_EXT2) begin
                  length_in = (nib == cop_pkg::NIB_EXT1) ? cop_pkg::EXT1_BASE
                                                        : cop_pkg::EXT2_BASE;
                  remain_in = (nib == cop_pkg::NIB_EXT1) ? 16'd1 : 16'd2;
                  phase_in  = PH_LEN_EXT;
                  if (last_byte) begin
                     bun.has_end   = 1'b1;
                     bun.end_kind  = cop_pkg::KIND_ERROR;
                     bun.end_error = cop_pkg::ERR_TRUNCATED;
                  end
               end else begin
                  length_in = 16'(nib);
                  do_finish = 1'b1;
               end
            end

            // header complete: new option number and value handling
            if (do_finish) begin
               number_in = number_ff + delta_in;
               isint     = int_rule_en && cop_pkg::is_integer_option(number_in);
               if (length_in == 16'd0) begin
                  bun.has_rec        = 1'b1;
                  bun.rec_number     = number_in;
                  bun.rec_is_integer = isint;
                  do_done            = 1'b1;
               end else if (last_byte) begin
                  bun.has_end   = 1'b1;
                  bun.end_kind  = cop_pkg::KIND_ERROR;
                  bun.end_error = cop_pkg::ERR_TRUNCATED;
               end else begin
                  remain_in = length_in;
                  if (isint) begin
                     acc_in   = 32'd0;
                     phase_in = (length_in > cop_pkg::INT_MAX_BYTES) ? PH_BAD_INT : PH_INT;
                  end else begin
                     bun.has_rec    = 1'b1;
                     bun.rec_number = number_in;
                     bun.rec_length = length_in;
                     phase_in       = PH_OPAQUE;
                  end
               end
            end

            if (do_done) begin
               phase_in = PH_HEADER;
               if (last_byte) begin
                  bun.has_end      = 1'b1;
                  bun.end_consumed = 16'(index_in);
               end
            end

            // end or error: start over on the last byte, else ignore until it
            if (bun.has_end) begin
               if (last_byte) begin
                  do_clear = 1'b1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end

         if (do_clear) begin
            phase_in  = PH_HEADER;
            number_in = '0;
            delta_in  = '0;
            length_in = '0;
            remain_in = '0;
            acc_in    = '0;
            index_in  = '0;
         end
      end
   end

   assign q_push = accept && (bun.has_rec || bun.has_end);
   assign q_data = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         number_ff <= '0;
         delta_ff  <= '0;
         length_ff <= '0;
         remain_ff <= '0;
         acc_ff    <= '0;
         index_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         number_ff <= number_in;
         delta_ff  <= delta_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
         acc_ff    <= acc_in;
         index_ff  <= index_in;
      end
   end

endmodule

### design/cop_queue.sv
// ----------------------------------------------------------------------------
// cop_queue: bundle queue between parser and output stage
// Small first-in first-out store of result bundles so that either side
// can stall on its own.
// ----------------------------------------------------------------------------
module cop_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cop_pkg::bundle_type  push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output cop_pkg::bundle_type  head
);

   cop_pkg::bundle_type                  mem_ff [cop_pkg::QUEUE_DEPTH];
   logic [cop_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [cop_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [cop_pkg::QUEUE_COUNT_BITS-1:0] count_ff,  count_in;
   logic                                 do_push, do_pop;

   assign full    = (count_ff == cop_pkg::QUEUE_COUNT_BITS'(cop_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == cop_pkg::QUEUE_PTR_BITS'(cop_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == cop_pkg::QUEUE_PTR_BITS'(cop_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/cop_back.sv
// ----------------------------------------------------------------------------
// cop_back: result output stage
// Splits each bundle into its results, one per cycle while results are
// taken, and holds the oldest result in an output register until it is taken.
// ----------------------------------------------------------------------------
module cop_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cop_pkg::bundle_type  head,
   input  logic                 head_valid,
   output logic                 head_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [1:0]           rsp_kind,
   output logic [15:0]          rsp_option_number,
   output logic [15:0]          rsp_value_length,
   output logic                 rsp_is_integer,
   output logic [31:0]          rsp_integer_value,
   output logic [7:0]           rsp_value_byte,
   output logic [1:0]           rsp_error_code,
   output logic [15:0]          rsp_consumed_length,
   output logic                 rsp_end_of_run
);

   logic        valid_ff,  valid_in;
   logic        sel_ff,    sel_in;
   logic        load, take_rec;
   logic [1:0]  kind_ff,   kind_in;
   logic [15:0] number_ff, number_in;
   logic [15:0] length_ff, length_in;
   logic        isint_ff,  isint_in;
   logic [31:0] ival_ff,   ival_in;
   logic [7:0]  vbyte_ff,  vbyte_in;
   logic [1:0]  err_ff,    err_in;
   logic [15:0] cons_ff,   cons_in;
   logic        eor_ff,    eor_in;

   // the output register refills, when the queue is not empty, whenever it is free or being taken
   assign load     = head_valid && (!valid_ff || rsp_pop);
   assign take_rec = head.has_rec && !sel_ff;
   assign head_pop = load && !(take_rec && head.has_end);

   always_comb begin
      valid_in  = valid_ff;
      sel_in    = sel_ff;
      kind_in   = kind_ff;
      number_in = number_ff;
      length_in = length_ff;
      isint_in  = isint_ff;
      ival_in   = ival_ff;
      vbyte_in  = vbyte_ff;
      err_in    = err_ff;
      cons_in   = cons_ff;
      eor_in    = eor_ff;
      if (load) begin
         valid_in = 1'b1;
         if (take_rec) begin
            kind_in   = head.rec_kind;
            number_in = head.rec_number;
            length_in = head.rec_length;
            isint_in  = head.rec_is_integer;
            ival_in   = head.rec_integer;
            vbyte_in  = head.rec_byte;
            err_in    = cop_pkg::ERR_NONE;
            cons_in   = '0;
            eor_in    = !head.has_end;
            sel_in    = head.has_end;
         end else begin
            kind_in   = head.end_kind;
            number_in = '0;
            length_in = '0;
            isint_in  = 1'b0;
            ival_in   = '0;
            vbyte_in  = '0;
            err_in    = head.end_error;
            cons_in   = head.end_consumed;
            eor_in    = 1'b1;
            sel_in    = 1'b0;
         end
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      number_ff <= number_in;
      length_ff <= length_in;
      isint_ff  <= isint_in;
      ival_ff   <= ival_in;
      vbyte_ff  <= vbyte_in;
      err_ff    <= err_in;
      cons_ff   <= cons_in;
      eor_ff    <= eor_in;
   end

   assign rsp_empty           = !valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_option_number   = number_ff;
   assign rsp_value_length    = length_ff;
   assign rsp_is_integer      = isint_ff;
   assign rsp_integer_value   = ival_ff;
   assign rsp_value_byte      = vbyte_ff;
   assign rsp_error_code      = err_ff;
   assign rsp_consumed_length = cons_ff;
   assign rsp_end_of_run      = eor_ff;

endmodule
